/* rtl/bba_pkg.sv */
// Package for the free-block bitmap allocator: payload structs, command and
// status codes, sequencer states and map geometry constants.
// No dependencies.
package bba_pkg;

  localparam int MAX_BLOCKS    = 4096;
  localparam int MAP_WORD_BITS = 32;
  localparam int MAP_WORDS     = (MAX_BLOCKS + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
  localparam int WORD_AW       = $clog2(MAP_WORDS);
  localparam int BIT_AW        = $clog2(MAP_WORD_BITS);
  localparam int IDX_W         = 12;
  localparam int CNT_W         = 13;
  localparam int OUT_LIMIT     = 4096;
  localparam int LIMIT_BLOCKS  = (MAX_BLOCKS < OUT_LIMIT) ? MAX_BLOCKS : OUT_LIMIT;

  localparam logic [IDX_W-1:0] NO_GRANT    = '0;
  localparam logic [CNT_W-1:0] TOTAL_RESET = CNT_W'(4096);

  localparam logic [1:0] CMD_ALLOC   = 2'd0;
  localparam logic [1:0] CMD_RELEASE = 2'd1;
  localparam logic [1:0] CMD_MARK    = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [IDX_W-1:0] block_index;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] granted_block;
    logic [1:0]       status;
  } out_item_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RMW
  } state_t;

endpackage

/* rtl/bitmap_block_allocator_core.sv */
// Top level of the free-block bitmap allocator: occupancy map memory, word scanner and
// the sequencer around it. Depends on bba_pkg.
// An allocate scans the map words upward from word 0 and ends at the first word with a free block,
// or reports full after the last word. Busy is low again in the cycle that carries the result beat,
// so a new command can be accepted while that result is shown; results never stall.
// Synchronous reset frees every block through per-word valid bits and sets total_blocks to 4096.
module bitmap_block_allocator_core
  import bba_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  in_item_t         in_data,
  output logic             out_strobe,
  output out_item_t        out_data,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_wdata
);

  state_t state_r, state_nxt;

  logic [CNT_W-1:0]         total_r;
  logic [MAP_WORD_BITS-1:0] mem [MAP_WORDS];
  logic [MAP_WORDS-1:0]     vld_r;
  logic [MAP_WORD_BITS-1:0] rdata_r;
  logic                     rvld_r;

  logic [WORD_AW-1:0] scan_r, scan_nxt;
  logic [WORD_AW-1:0] chk_r, chk_nxt;
  logic               iss_r, iss_nxt;
  logic               pend_r, pend_nxt;
  logic [1:0]         op_cmd_r;
  logic [IDX_W-1:0]   op_idx_r;

  logic               out_strobe_r, out_strobe_nxt;
  out_item_t          out_r, out_nxt;

  logic               accept;
  logic [CNT_W-1:0]   n_eff;
  logic [CNT_W-1:0]   n_m1;
  logic [WORD_AW-1:0] last_word;
  logic [BIT_AW-1:0]  last_bit;
  logic [WORD_AW-1:0] raddr;
  logic               we;
  logic [WORD_AW-1:0] waddr;
  logic [MAP_WORD_BITS-1:0] wdata;
  logic [MAP_WORD_BITS-1:0] cur_word;
  logic [MAP_WORD_BITS-1:0] lim_mask;
  logic [MAP_WORD_BITS-1:0] free_bits;
  logic               hit;
  logic [BIT_AW-1:0]  hit_bit;
  logic [MAP_WORD_BITS-1:0] bit_sel;

  assign accept = start && !busy;
  assign busy   = (state_r != S_IDLE);

  // Effective count, saturated to the map size and to what granted_block can carry.
  assign n_eff     = (total_r > CNT_W'(LIMIT_BLOCKS)) ? CNT_W'(LIMIT_BLOCKS) : total_r;
  assign n_m1      = n_eff - CNT_W'(1);
  assign last_word = n_m1[BIT_AW +: WORD_AW];
  assign last_bit  = n_m1[BIT_AW-1:0];

  // A word that was never written since reset reads as all free.
  assign cur_word = rvld_r ? rdata_r : '0;

  assign lim_mask = (chk_r == last_word) ?
                    ({MAP_WORD_BITS{1'b1}} >> (BIT_AW'(MAP_WORD_BITS - 1) - last_bit)) :
                    {MAP_WORD_BITS{1'b1}};
  assign free_bits = ~cur_word & lim_mask;
  assign hit       = |free_bits;

  always_comb begin
    hit_bit = '0;
    for (int i = MAP_WORD_BITS - 1; i >= 0; i--) begin
      if (free_bits[i]) begin
        hit_bit = BIT_AW'(i);
      end
    end
  end

  assign bit_sel = MAP_WORD_BITS'(1) << op_idx_r[BIT_AW-1:0];

  always_comb begin
    if (state_r == S_SCAN) begin
      raddr = scan_r;
    end else if (in_data.cmd == CMD_ALLOC) begin
      raddr = '0;
    end else begin
      raddr = in_data.block_index[BIT_AW +: WORD_AW];
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_data.cmd)
            CMD_ALLOC: begin
              if (n_eff != '0) begin
                state_nxt = S_SCAN;
              end
            end
            CMD_RELEASE, CMD_MARK: begin
              if ({1'b0, in_data.block_index} < n_eff) begin
                state_nxt = S_RMW;
              end
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_SCAN: begin
        if (pend_r && (hit || !iss_r)) begin
          state_nxt = S_IDLE;
        end
      end
      S_RMW:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs, scan control and map writes.
  always_comb begin
    scan_nxt       = scan_r;
    chk_nxt        = chk_r;
    iss_nxt        = iss_r;
    pend_nxt       = 1'b0;
    out_strobe_nxt = 1'b0;
    out_nxt        = out_r;
    we             = 1'b0;
    waddr          = chk_r;
    wdata          = cur_word;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_nxt.granted_block = NO_GRANT;
          case (in_data.cmd)
            CMD_ALLOC: begin
              // Word 0 is read during the accept cycle.
              scan_nxt = WORD_AW'(1);
              chk_nxt  = '0;
              pend_nxt = 1'b1;
              iss_nxt  = (last_word != '0);
              if (n_eff == '0) begin
                out_strobe_nxt = 1'b1;
                out_nxt.status = ST_FULL;
              end
            end
            CMD_RELEASE, CMD_MARK: begin
              if ({1'b0, in_data.block_index} >= n_eff) begin
                out_strobe_nxt = 1'b1;
                out_nxt.status = ST_RANGE;
              end
            end
            default: begin
              out_strobe_nxt = 1'b1;
              out_nxt.status = ST_RANGE;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (iss_r) begin
          pend_nxt = 1'b1;
          chk_nxt  = scan_r;
          if (scan_r == last_word) begin
            iss_nxt = 1'b0;
          end else begin
            scan_nxt = scan_r + WORD_AW'(1);
          end
        end
        if (pend_r && hit) begin
          we                    = 1'b1;
          waddr                 = chk_r;
          wdata                 = cur_word | (MAP_WORD_BITS'(1) << hit_bit);
          out_strobe_nxt        = 1'b1;
          out_nxt.granted_block = IDX_W'({chk_r, hit_bit});
          out_nxt.status        = ST_OK;
        end else if (pend_r && !iss_r) begin
          out_strobe_nxt        = 1'b1;
          out_nxt.granted_block = NO_GRANT;
          out_nxt.status        = ST_FULL;
        end
      end
      S_RMW: begin
        we    = 1'b1;
        waddr = op_idx_r[BIT_AW +: WORD_AW];
        wdata = (op_cmd_r == CMD_MARK) ? (cur_word | bit_sel) : (cur_word & ~bit_sel);
        out_strobe_nxt        = 1'b1;
        out_nxt.granted_block = NO_GRANT;
        out_nxt.status        = ST_OK;
      end
      default: begin
        out_strobe_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
    if (accept) begin
      op_cmd_r <= in_data.cmd;
      op_idx_r <= in_data.block_index;
    end
    scan_r  <= scan_nxt;
    chk_r   <= chk_nxt;
    out_r   <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      total_r      <= TOTAL_RESET;
      vld_r        <= '0;
      rvld_r       <= 1'b0;
      iss_r        <= 1'b0;
      pend_r       <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      iss_r        <= iss_nxt;
      pend_r       <= pend_nxt;
      out_strobe_r <= out_strobe_nxt;
      rvld_r       <= vld_r[raddr];
      if (we) begin
        vld_r[waddr] <= 1'b1;
      end
      if (cfg_we) begin
        total_r <= cfg_wdata;
      end
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_r;

endmodule
